@@ rtl/core/bbcr_pkg.sv @@
package bbcr_pkg;

    localparam int SINE_W     = 16;
    localparam int INTEG_W    = 40;
    localparam int PHASE_W    = 32;
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT    = 2'd2;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST    = 32'd106255701;
    localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST = 7'd41;
    localparam logic [WIN_W-1:0]   SCAN_LIMIT_RST    = 7'd40;

    typedef longint unsigned u64_t;

    // 2*pi in Q3.30
    localparam u64_t TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD_RD,
        ST_OLD_LAT,
        ST_WALK_RD,
        ST_WALK_ADD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SIN_RD,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic sat_en;
    } alu_ctrl_t;

    // Quarter wave magnitude, Q1.15, from a truncated odd Taylor series.
    // Evaluated at elaboration only.
    function automatic logic [SINE_W-2:0] quarter_sine(input int unsigned m,
                                                        input int unsigned tbits);
        u64_t   x;
        u64_t   term;
        u64_t   v;
        longint sum;
        x    = ((u64_t'(m) * TWO_PI_Q30) + (64'd1 << (tbits - 1))) >> tbits;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (u64_t'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[SINE_W-2:0];
    endfunction

endpackage

@@ rtl/core/bbcr_ram.sv @@
module bbcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bbcr_sine_rom.sv @@
module bbcr_sine_rom import bbcr_pkg::*; #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                              clk,
    input  logic [SINE_TABLE_BITS-1:0]        idx,
    output logic signed [SINE_W-1:0]          sine
);

    localparam int HALF    = 2 ** (SINE_TABLE_BITS - 1);
    localparam int QUARTER = 2 ** (SINE_TABLE_BITS - 2);
    localparam int M_W     = SINE_TABLE_BITS - 1;

    logic [SINE_W-2:0] qtab [QUARTER+1];
    logic [M_W-1:0]    u;
    logic [M_W-1:0]    m;
    logic [SINE_W-2:0] mag_reg;
    logic              neg_reg;

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_tab
        assign qtab[g] = quarter_sine(g, SINE_TABLE_BITS);
    end

    // fold the half wave onto the quarter table
    always_comb
    begin
        u = idx[M_W-1:0];
        if (u <= M_W'(QUARTER))
            m = u;
        else
            m = M_W'(HALF - int'(u));
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= qtab[m];
        neg_reg <= idx[SINE_TABLE_BITS-1];
    end

    assign sine = neg_reg ? -signed'({1'b0, mag_reg}) : signed'({1'b0, mag_reg});

endmodule

@@ rtl/core/bbcr_alu.sv @@
module bbcr_alu import bbcr_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  alu_ctrl_t                              ctrl,
    input  logic signed [SAMPLE_BITS-1:0]          mul_a,
    input  logic signed [SINE_W-1:0]               mul_b,
    input  logic signed [INTEG_W-1:0]              add_a,
    input  logic signed [INTEG_W-1:0]              add_b,
    output logic signed [SAMPLE_BITS+SINE_W-1:0]   prod,
    output logic signed [INTEG_W-1:0]              sum
);

    localparam int PROD_W = SAMPLE_BITS + SINE_W;
    localparam logic signed [INTEG_W-1:0] SMAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] SMIN = {1'b1, {(INTEG_W-1){1'b0}}};

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [INTEG_W:0]   wide;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

    always_comb
    begin
        wide = {add_a[INTEG_W-1], add_a} + {add_b[INTEG_W-1], add_b};
        // clamp on overflow when saturating, wrap otherwise
        if (ctrl.sat_en && (wide[INTEG_W] != wide[INTEG_W-1]))
            sum = wide[INTEG_W] ? SMIN : SMAX;
        else
            sum = wide[INTEG_W-1:0];
    end

endmodule

@@ rtl/core/biphase_bit_clock_recovery.sv @@
// Biphase bit clock recovery and differential bit decoder. Each input item is
// one baseband sample (tdata) plus a resync flag (tuser); each produces exactly
// one result item: tdata[0] the decoded bit, tuser[0] bit present, tuser[1]
// bit clock realigned on this sample. Samples are delayed by one window in a
// ring, multiplied by the bit clock sine and integrated; on a rising zero
// crossing of the sine a bit is emitted and the integrator cleared. For a plain
// sample the ring read, the sine lookup, the product and the saturating
// accumulate run one after another before the block is ready again, and the
// block also waits while the previous result is not yet taken. A resync
// (after reset or on request) adds a correlation walk with a read and an add
// step per ring entry, since the correlation memory has one read and one write
// port, plus a read and a check step per entry visited by the edge scan (at
// most min(scan_limit, L) entries). Ring and correlation memories read as zero
// until written through per-entry valid flags, so no clearing pass is needed
// after reset. Configuration writes are always taken and belong in idle time only.
module biphase_bit_clock_recovery import bbcr_pkg::*; #(
    parameter int MAX_WINDOW      = 64,
    parameter int SAMPLE_BITS     = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic [0:0]                           s_axis_tuser,  // [0] resync_request
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [0] data_bit
    output logic [1:0]                           m_axis_tuser   // [0] bit_valid, [1] resynced
);

    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (LEN_W > WIN_W) ? LEN_W : WIN_W;
    localparam int CORR_W = SAMPLE_BITS + IDX_W;
    localparam int PROD_W = SAMPLE_BITS + SINE_W;
    localparam int PACC_W = PHASE_W + 1;

    state_t state_reg;
    state_t state_next;

    logic [PHASE_W-1:0] step_reg;
    logic [WIN_W-1:0]   wlen_reg;
    logic [WIN_W-1:0]   slim_reg;

    logic [IDX_W-1:0]        ring_ptr_reg;
    logic [MAX_WINDOW-1:0]   ring_vld_reg;
    logic [MAX_WINDOW-1:0]   corr_vld_reg;
    logic                    ring_rv_reg;
    logic                    corr_rv_reg;
    logic                    resync_pending_reg;
    logic                    rs_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;

    logic [IDX_W-1:0]   widx_reg;
    logic [LEN_W-1:0]   wi_reg;
    logic [IDX_W-1:0]   wk_reg;
    logic [IDX_W-1:0]   kcur_reg;
    logic               high_reg;
    logic [PACC_W-1:0]  wacc_reg;
    logic [LEN_W-1:0]   sidx_reg;
    logic               second_reg;
    logic [PHASE_W-1:0] negm_reg;

    logic [PHASE_W-1:0]        phase_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic                      prev_pos_reg;
    logic                      prev_bit_reg;
    logic                      clk_pos_reg;
    logic                      res_valid_reg;
    logic                      res_bit_reg;

    logic m_valid_reg;
    logic m_bit_reg;
    logic m_bv_reg;
    logic m_rs_reg;

    // derived configuration
    logic [CMP_W-1:0] wl_ext;
    logic [CMP_W-1:0] sl_ext;
    logic [CMP_W-1:0] len_ext;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] scan_lim;

    logic             in_fire;
    logic [IDX_W-1:0] acc_p;
    logic [IDX_W-1:0] acc_p_nx;
    logic [IDX_W-1:0] widx_nx;

    logic [SINE_TABLE_BITS-1:0] wph;
    logic                       w_pos;
    logic                       w_neg;
    logic [IDX_W-1:0]           k_eff;
    logic                       high_nx;

    logic                          ring_we;
    logic [IDX_W-1:0]              ring_raddr;
    logic [SAMPLE_BITS-1:0]        ring_rdata;
    logic signed [SAMPLE_BITS-1:0] ring_val;
    logic                          st_we;
    logic [IDX_W-1:0]              st_raddr;
    logic [CORR_W-1:0]             st_rdata;
    logic signed [CORR_W-1:0]      corr_val;
    logic                          corr_pos;
    logic                          corr_neg;
    logic                          scan_stop;

    alu_ctrl_t                 alu_ctrl;
    logic signed [INTEG_W-1:0] alu_a;
    logic signed [INTEG_W-1:0] alu_b;
    logic signed [PROD_W-1:0]  alu_prod;
    logic signed [INTEG_W-1:0] alu_sum;

    logic [PACC_W-1:0] pa;
    logic [PACC_W-1:0] pb;
    logic              pcin;
    logic [PACC_W-1:0] padd;

    logic signed [SINE_W-1:0] rom_sine;
    logic                     edge_det;

    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        wl_ext = CMP_W'(wlen_reg);
        sl_ext = CMP_W'(slim_reg);
        if (wl_ext == '0)
            len_ext = CMP_W'(1);
        else if (wl_ext > CMP_W'(MAX_WINDOW))
            len_ext = CMP_W'(MAX_WINDOW);
        else
            len_ext = wl_ext;
        eff_len  = LEN_W'(len_ext);
        scan_lim = LEN_W'((sl_ext < len_ext) ? sl_ext : len_ext);
    end

    // ring pointer wraps early if the window shrank
    always_comb
    begin
        acc_p    = (LEN_W'(ring_ptr_reg) >= eff_len) ? '0 : ring_ptr_reg;
        acc_p_nx = (LEN_W'(acc_p) + LEN_W'(1) >= eff_len) ? '0 : acc_p + IDX_W'(1);
        widx_nx  = (LEN_W'(widx_reg) + LEN_W'(1) >= eff_len) ? '0 : widx_reg + IDX_W'(1);
    end

    // sign of the half rate sine; zero only at the two crossings
    always_comb
    begin
        wph     = wacc_reg[PACC_W-1 -: SINE_TABLE_BITS];
        w_pos   = !wph[SINE_TABLE_BITS-1] && (wph != '0);
        w_neg   = wph[SINE_TABLE_BITS-1] && (wph[SINE_TABLE_BITS-2:0] != '0);
        k_eff   = ((w_pos && !high_reg) || (w_neg && high_reg)) ? '0 : wk_reg;
        high_nx = w_pos ? 1'b1 : (w_neg ? 1'b0 : high_reg);
    end

    assign ring_val  = ring_rv_reg ? signed'(ring_rdata) : '0;
    assign corr_val  = corr_rv_reg ? signed'(st_rdata) : '0;
    assign corr_pos  = !corr_val[CORR_W-1] && (corr_val != '0);
    assign corr_neg  = corr_val[CORR_W-1];
    assign scan_stop = second_reg ? !corr_neg : 1'b0;
    assign edge_det  = !prev_pos_reg && clk_pos_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_OLD_RD;
            ST_OLD_RD:
                state_next = ST_OLD_LAT;
            ST_OLD_LAT:
                state_next = rs_reg ? ST_WALK_RD : ST_SIN_RD;
            ST_WALK_RD:
                state_next = ST_WALK_ADD;
            ST_WALK_ADD:
                state_next = (wi_reg == eff_len) ? ST_SCAN_RD : ST_WALK_RD;
            ST_SCAN_RD:
                state_next = (sidx_reg >= scan_lim) ? ST_SIN_RD : ST_SCAN_CHK;
            ST_SCAN_CHK:
                state_next = scan_stop ? ST_SIN_RD : ST_SCAN_RD;
            ST_SIN_RD:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
                state_next = ST_DONE;
            ST_DONE:
                if (!m_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ring_we         = in_fire;
        ring_raddr      = (state_reg == ST_WALK_RD) ? widx_reg : ring_ptr_reg;
        st_we           = (state_reg == ST_WALK_ADD);
        st_raddr        = '0;
        alu_ctrl.mul_en = (state_reg == ST_MUL);
        alu_ctrl.sat_en = (state_reg == ST_ACC);
        alu_a           = INTEG_W'(ring_val);
        alu_b           = INTEG_W'(corr_val);
        pa              = {1'b0, phase_reg};
        pb              = {1'b0, step_reg};
        pcin            = 1'b0;
        case (state_reg)
            ST_WALK_RD:
            begin
                st_raddr = k_eff;
                pa       = wacc_reg;
            end
            ST_SCAN_RD:
            begin
                if (sidx_reg < scan_lim)
                    st_raddr = sidx_reg[IDX_W-1:0];
                pa   = {1'b0, negm_reg};
                pb   = {1'b1, ~step_reg};
                pcin = 1'b1;
            end
            ST_ACC:
            begin
                alu_a = integ_reg;
                alu_b = INTEG_W'(alu_prod);
            end
            default:
            begin
            end
        endcase
    end

    assign padd = pa + pb + PACC_W'(pcin);

    bbcr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (acc_p),
        .wdata (s_axis_tdata[SAMPLE_BITS-1:0]),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    bbcr_ram #(
        .WIDTH (CORR_W),
        .DEPTH (MAX_WINDOW)
    ) u_corr (
        .clk   (clk),
        .we    (st_we),
        .waddr (kcur_reg),
        .wdata (alu_sum[CORR_W-1:0]),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    bbcr_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .clk  (clk),
        .idx  (phase_reg[PHASE_W-1 -: SINE_TABLE_BITS]),
        .sine (rom_sine)
    );

    bbcr_alu #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_alu (
        .clk   (clk),
        .ctrl  (alu_ctrl),
        .mul_a (old_reg),
        .mul_b (rom_sine),
        .add_a (alu_a),
        .add_b (alu_b),
        .prod  (alu_prod),
        .sum   (alu_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            step_reg           <= PHASE_STEP_RST;
            wlen_reg           <= WINDOW_LENGTH_RST;
            slim_reg           <= SCAN_LIMIT_RST;
            ring_ptr_reg       <= '0;
            ring_vld_reg       <= '0;
            corr_vld_reg       <= '0;
            ring_rv_reg        <= 1'b0;
            corr_rv_reg        <= 1'b0;
            resync_pending_reg <= 1'b1;
            rs_reg             <= 1'b0;
            old_reg            <= '0;
            widx_reg           <= '0;
            wi_reg             <= '0;
            wk_reg             <= '0;
            kcur_reg           <= '0;
            high_reg           <= 1'b0;
            wacc_reg           <= '0;
            sidx_reg           <= '0;
            second_reg         <= 1'b0;
            negm_reg           <= '0;
            phase_reg          <= '0;
            integ_reg          <= '0;
            prev_pos_reg       <= 1'b0;
            prev_bit_reg       <= 1'b0;
            clk_pos_reg        <= 1'b0;
            res_valid_reg      <= 1'b0;
            res_bit_reg        <= 1'b0;
            m_valid_reg        <= 1'b0;
            m_bit_reg          <= 1'b0;
            m_bv_reg           <= 1'b0;
            m_rs_reg           <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ring_rv_reg <= ring_vld_reg[ring_raddr];
            corr_rv_reg <= corr_vld_reg[st_raddr];

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PHASE_STEP:    step_reg <= cfg_data[PHASE_W-1:0];
                    CFG_WINDOW_LENGTH: wlen_reg <= cfg_data[WIN_W-1:0];
                    CFG_SCAN_LIMIT:    slim_reg <= cfg_data[WIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_fire)
            begin
                ring_vld_reg[acc_p] <= 1'b1;
                ring_ptr_reg        <= acc_p_nx;
                rs_reg              <= resync_pending_reg | s_axis_tuser[0];
            end

            case (state_reg)
                ST_OLD_LAT:
                begin
                    old_reg <= ring_val;
                    if (rs_reg)
                    begin
                        resync_pending_reg <= 1'b0;
                        corr_vld_reg       <= '0;
                        widx_reg           <= ring_ptr_reg;
                        wi_reg             <= '0;
                        wk_reg             <= '0;
                        high_reg           <= 1'b0;
                        wacc_reg           <= '0;
                    end
                end
                ST_WALK_RD:
                begin
                    kcur_reg <= k_eff;
                    wk_reg   <= k_eff + IDX_W'(1);
                    high_reg <= high_nx;
                    wacc_reg <= padd;
                    widx_reg <= widx_nx;
                    wi_reg   <= wi_reg + LEN_W'(1);
                end
                ST_WALK_ADD:
                begin
                    corr_vld_reg[kcur_reg] <= 1'b1;
                    // scan starts at entry 0 with phase -step*(0-1)
                    sidx_reg   <= '0;
                    second_reg <= 1'b0;
                    negm_reg   <= step_reg;
                end
                ST_SCAN_RD:
                begin
                    if (sidx_reg >= scan_lim)
                        phase_reg <= negm_reg;
                    else
                    begin
                        sidx_reg <= sidx_reg + LEN_W'(1);
                        negm_reg <= padd[PHASE_W-1:0];
                    end
                end
                ST_SCAN_CHK:
                begin
                    if (scan_stop)
                        phase_reg <= negm_reg;
                    else if (!second_reg && !corr_pos)
                        second_reg <= 1'b1;
                end
                ST_MUL:
                    clk_pos_reg <= !rom_sine[SINE_W-1] && (rom_sine != '0);
                ST_ACC:
                begin
                    prev_pos_reg <= clk_pos_reg;
                    phase_reg    <= padd[PHASE_W-1:0];
                    if (edge_det)
                    begin
                        integ_reg     <= '0;
                        prev_bit_reg  <= !alu_sum[INTEG_W-1];
                        res_valid_reg <= 1'b1;
                        res_bit_reg   <= !alu_sum[INTEG_W-1] ^ prev_bit_reg;
                    end
                    else
                    begin
                        integ_reg     <= alu_sum;
                        res_valid_reg <= 1'b0;
                        res_bit_reg   <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase

            // hold the result until taken, then load the next one
            if (state_reg == ST_DONE && (!m_valid_reg || m_axis_tready))
            begin
                m_valid_reg <= 1'b1;
                m_bv_reg    <= res_valid_reg;
                m_bit_reg   <= res_bit_reg;
                m_rs_reg    <= rs_reg;
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_bit_reg};
    assign m_axis_tuser  = {m_rs_reg, m_bv_reg};

    a_run_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_ADD) |-> (LEN_W'(kcur_reg) < wi_reg))
        else $error("correlation run index ran past walk position");

    a_walk_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_RD && wi_reg == '0) |-> (corr_vld_reg == '0))
        else $error("correlation store not cleared at walk start");

    a_pending_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> !resync_pending_reg)
        else $error("pending resync not taken before integration");

    a_integ_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && edge_det) |=> (integ_reg == '0))
        else $error("integrator not cleared after bit decision");

endmodule

@@ verif/tb.sv @@
module tb;
    import bbcr_pkg::*;

    localparam int TBL_BITS      = 10;
    localparam int RING_DEPTH    = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int PRINT_CAP     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam longint INTEG_TOP = 64'sd549755813887;
    localparam longint INTEG_BOT = -INTEG_TOP - 1;

    typedef struct packed {
        logic bit_valid;
        logic data_bit;
        logic resynced;
    } decode_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;  // [15:0] sample
    logic [0:0]            s_axis_tuser  = '0;  // [0] resync_request
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [0] data_bit
    logic [1:0]            m_axis_tuser;        // [0] bit_valid, [1] resynced

    // bit clock recovery state as the block should hold it
    shortint     sine_lut [1 << TBL_BITS];
    int          ring_mem [RING_DEPTH];
    int          corr_acc [RING_DEPTH];
    int unsigned ring_ptr    = 0;
    logic [31:0] clk_phase   = '0;
    longint      integ       = 0;
    int          last_sine   = 0;
    logic        last_bit    = 1'b0;
    bit          need_resync = 1'b1;
    logic [31:0] step_reg    = PHASE_STEP_RST;
    logic [6:0]  win_reg     = WINDOW_LENGTH_RST;
    logic [6:0]  scan_reg    = SCAN_LIMIT_RST;

    decode_t pending_decodes [$];
    decode_t want;
    int      fail_count   = 0;
    int      result_count = 0;
    int      quiet_cycles = 0;
    bit      idle_on      = 1'b1;
    bit      hold_request = 1'b0;

    biphase_bit_clock_recovery DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // first quadrant of the sine, Q1.15, odd Taylor series through x^13 in Q2.30
    function automatic int quarter_mag(input int unsigned m);
        longint unsigned x;
        longint unsigned t;
        longint unsigned v;
        longint          acc;
        x   = (longint'(m) * TWO_PI_Q30 + (64'd1 << (TBL_BITS - 1))) >> TBL_BITS;
        t   = x;
        acc = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / longint'((2 * k) * (2 * k + 1));
            if (k % 2)
                acc = acc - longint'(t);
            else
                acc = acc + longint'(t);
        end
        if (acc < 0)
            acc = 0;
        v = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        return (v > 64'd32767) ? 32767 : int'(v);
    endfunction

    function automatic int sine_at(input logic [31:0] ph);
        return sine_lut[ph[31 -: TBL_BITS]];
    endfunction

    function automatic int unsigned eff_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > RING_DEPTH)
            return RING_DEPTH;
        return win_reg;
    endfunction

    // correlate the window against half rate sine sign runs, set phase from first rising edge
    function automatic void realign_clock(input int unsigned first, input int unsigned len);
        logic        high;
        int unsigned k;
        int unsigned idx;
        int unsigned lim;
        logic [63:0] prod;
        int          s;
        int          v;
        high = 1'b0;
        k    = 0;
        idx  = 0;
        lim  = (scan_reg < len) ? scan_reg : len;
        for (int i = 0; i < RING_DEPTH; i++)
            corr_acc[i] = 0;
        for (int unsigned i = 0; i < len; i++)
        begin
            prod = 64'(i) * 64'(step_reg);
            s    = sine_at(prod[32:1]);
            if (s > 0 && !high)
            begin
                high = 1'b1;
                k    = 0;
            end
            else if (s < 0 && high)
            begin
                high = 1'b0;
                k    = 0;
            end
            corr_acc[k] += ring_mem[(first + i) % len];
            k++;
        end
        // the scan steps past the entry that ends each run
        while (idx < lim)
        begin
            v = corr_acc[idx];
            idx++;
            if (v <= 0)
                break;
        end
        while (idx < lim)
        begin
            v = corr_acc[idx];
            idx++;
            if (v >= 0)
                break;
        end
        clk_phase = 32'd0 - step_reg * (idx - 32'd1);
    endfunction

    function automatic decode_t recover_bit(input logic [15:0] raw, input logic req);
        int unsigned len;
        int          old;
        int          sn;
        longint      sum;
        decode_t     r;
        r   = '0;
        len = eff_window();
        if (ring_ptr >= len)
            ring_ptr = 0;
        ring_mem[ring_ptr] = int'($signed(raw));
        ring_ptr = (ring_ptr + 1 >= len) ? 0 : ring_ptr + 1;
        old = ring_mem[ring_ptr];
        if (need_resync || req)
        begin
            realign_clock(ring_ptr, len);
            need_resync = 1'b0;
            r.resynced  = 1'b1;
        end
        sn  = sine_at(clk_phase);
        sum = integ + longint'(old) * longint'(sn);
        if (sum > INTEG_TOP)
            sum = INTEG_TOP;
        if (sum < INTEG_BOT)
            sum = INTEG_BOT;
        integ = sum;
        if (last_sine <= 0 && sn > 0)
        begin
            r.bit_valid = 1'b1;
            r.data_bit  = (integ >= 0) ^ last_bit;
            last_bit    = (integ >= 0);
            integ       = 0;
        end
        last_sine = sn;
        clk_phase = clk_phase + step_reg;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("ERROR @%0t: %s", $time, what);
    endtask

    task automatic push_sample(input logic [15:0] smp, input logic req);
        while (idle_on && $urandom_range(99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_decodes.push_back(recover_bit(smp, req));
    endtask

    // drop the input and wait until every decode is back and the block is idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] step, input logic [31:0] win,
                             input logic [31:0] scan);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [31:0]          vals [4];
        settle();
        regs = '{CFG_PHASE_STEP, CFG_WINDOW_LENGTH, CFG_SCAN_LIMIT, CFG_SPARE};
        vals = '{step, win, scan, $urandom};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (regs[i])
                CFG_PHASE_STEP:    step_reg = vals[i];
                CFG_WINDOW_LENGTH: win_reg  = vals[i][6:0];
                CFG_SCAN_LIMIT:    scan_reg = vals[i][6:0];
                default:           ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // biphase symbols one window long with noise, some raw noise and phase slips
    task automatic send_waveform(input int count, input int resync_pct);
        int unsigned L;
        int unsigned pos;
        int          amp;
        int          lvl;
        logic        sym;
        logic [15:0] smp;
        amp = $urandom_range(30000, 2000);
        pos = 0;
        sym = 1'b0;
        for (int j = 0; j < count; j++)
        begin
            L = eff_window();
            if (pos >= L)
                pos = 0;
            if ($urandom_range(99) < 3)
                pos = $urandom_range(L - 1);
            if (pos == 0)
                sym = $urandom_range(1);
            if ($urandom_range(99) < 10)
                smp = $urandom;
            else
            begin
                lvl = (pos < (L + 1) / 2) ? amp : -amp;
                if (sym)
                    lvl = -lvl;
                lvl = lvl + int'($urandom_range(2047)) - 1024;
                smp = lvl[15:0];
            end
            push_sample(smp, $urandom_range(99) < resync_pct);
            pos++;
        end
    endtask

    task automatic test_field_extremes();
        logic [15:0] smps [7];
        logic        reqs [7];
        smps = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
        reqs = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        for (int i = 0; i < 7; i++)
            push_sample(smps[i], reqs[i]);
    endtask

    task automatic test_window_edges();
        // one sample window, pointer left beyond it
        configure(PHASE_STEP_RST, 32'd1, 32'd1);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h1234, 1'b0);
        // zero window and zero scan limit
        configure(32'hFFFF_FFFF, 32'd0, 32'd0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'hFFFF, 1'b0);
        // oversized window and scan limit clamp to the ring size
        configure(32'h8000_0000, 32'd127, 32'd127);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h4000, 1'b1);
        // only the low seven bits of the length registers count
        configure(32'd0, 32'h0000_0085, 32'hFFFF_FFC3);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h0000, 1'b0);
    endtask

    task automatic test_random_settings();
        int unsigned L;
        logic [63:0] q;
        logic [31:0] st;
        for (int n = 0; n < 8; n++)
        begin
            case (n)
                0: configure(PHASE_STEP_RST, 32'(WINDOW_LENGTH_RST), 32'(SCAN_LIMIT_RST));
                1: configure(32'hFFFF_FFFF, 32'd64, 32'd64);
                2: configure(32'd1, 32'd2, 32'd1);
                3: configure(32'h0400_0000, 32'd64, 32'd63);
                default:
                begin
                    L  = $urandom_range(16, 2);
                    q  = 64'h1_0000_0000 / L;
                    st = q[31:0] + 32'($urandom_range(4194304)) - 32'd2097152;
                    configure(st, 32'(L), 32'($urandom_range(L + 2, 1)));
                end
            endcase
            send_waveform(75, 3);
        end
    endtask

    task automatic test_backpressure();
        configure(32'd715827882, 32'd6, 32'd6);
        hold_request = 1'b1;
        send_waveform(40, 2);
        settle();
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        configure(32'd357913941, 32'd12, 32'd11);
        send_waveform(150, 1);
        settle();
        idle_on = 1'b1;
    endtask

    initial
    begin
        for (int n = 0; n < (1 << TBL_BITS); n++)
        begin
            int unsigned u;
            int unsigned m;
            int          mag;
            u   = n % (1 << (TBL_BITS - 1));
            m   = (u <= (1 << (TBL_BITS - 2))) ? u : (1 << (TBL_BITS - 1)) - u;
            mag = quarter_mag(m);
            sine_lut[n] = shortint'((n >= (1 << (TBL_BITS - 1))) ? -mag : mag);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_window_edges();
        test_random_settings();
        test_backpressure();
        test_no_idle();
        settle();
        if (pending_decodes.size() != 0)
            report_mismatch($sformatf("%0d decodes never arrived", pending_decodes.size()));
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, and one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= !(idle_on && $urandom_range(99) < 25);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (pending_decodes.size() == 0)
                report_mismatch($sformatf("result %0d with no sample outstanding",
                                          result_count));
            else
            begin
                want = pending_decodes.pop_front();
                if (m_axis_tuser[0] !== want.bit_valid)
                    report_mismatch($sformatf("result %0d: bit_valid %b, expected %b",
                                              result_count, m_axis_tuser[0], want.bit_valid));
                if (m_axis_tdata !== {7'd0, want.data_bit})
                    report_mismatch($sformatf("result %0d: tdata %h, expected data_bit %b",
                                              result_count, m_axis_tdata, want.data_bit));
                if (m_axis_tuser[1] !== want.resynced)
                    report_mismatch($sformatf("result %0d: resynced %b, expected %b",
                                              result_count, m_axis_tuser[1], want.resynced));
            end
        end
    end

    // end the run if no item moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("ERROR @%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

@@ biphase_bit_clock_recovery.f @@
rtl/core/bbcr_pkg.sv
rtl/core/bbcr_ram.sv
rtl/core/bbcr_sine_rom.sv
rtl/core/bbcr_alu.sv
rtl/core/biphase_bit_clock_recovery.sv
verif/tb.sv
